// ----- src/kwsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_pkg
// Shared constants, types and helpers of the k-way sorted merge.
// ----------------------------------------------------------------------------
package kwsm_pkg;

  localparam int LANES       = 8;
  localparam int VALUE_WIDTH = 32;
  localparam int LANE_W      = $clog2(LANES);
  localparam int NPAIR       = (LANES + 1) / 2;
  localparam int CFG_W       = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FINISH,
    OP_BAD_LANE
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PICK
  } state_e;

  typedef struct packed {
    op_e                            op;
    logic [LANE_W-1:0]              lane;
    logic signed [VALUE_WIDTH-1:0]  value;
    logic                           last;
  } q_item_t;

  typedef struct packed {
    logic                           vld;
    logic [LANE_W-1:0]              lane;
    logic signed [VALUE_WIDTH-1:0]  value;
  } cand_t;

  function automatic logic [LANES-1:0] lanes_mask(input logic [CFG_W-1:0] n);
    int               cnt;
    logic [LANES-1:0] m;
    cnt = int'(n);
    if (cnt < 1) cnt = 1;
    if (cnt > LANES) cnt = LANES;
    for (int i = 0; i < LANES; i++) begin
      m[i] = (i < cnt);
    end
    return m;
  endfunction

  // Lower lane wins a tie.
  function automatic cand_t min_of(input cand_t a, input cand_t b);
    if (b.vld && (!a.vld || (b.value < a.value))) begin
      return b;
    end
    return a;
  endfunction

endpackage

// ----- src/kwsm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_in_if / kwsm_out_if
// Valid/ready channels carrying merge input items and merge results.
// ----------------------------------------------------------------------------
interface kwsm_in_if;
  import kwsm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [LANE_W-1:0]             lane;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          lane_last;
  logic                          lane_empty;

  modport source (output valid, lane, value, lane_last, lane_empty, input ready);
  modport sink   (input valid, lane, value, lane_last, lane_empty, output ready);
endinterface

interface kwsm_out_if;
  import kwsm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] merged_value;
  logic [LANE_W-1:0]             source_lane;
  logic                          merge_done;
  logic                          protocol_error;

  modport source (output valid, merged_value, source_lane, merge_done, protocol_error,
                  input ready);
  modport sink   (input valid, merged_value, source_lane, merge_done, protocol_error,
                  output ready);
endinterface

// ----- src/kwsm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_front
// Accepts input items, tags each with its operation and queues it.
// ----------------------------------------------------------------------------
module kwsm_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [kwsm_pkg::LANES-1:0] active_i,
  kwsm_in_if.sink                 in_i,
  output logic                    q_vld_o,
  output kwsm_pkg::q_item_t       q_item_o,
  input  logic                    q_pop_i
);
  import kwsm_pkg::*;

  q_item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                push;
  logic                pop;
  q_item_t             item;

  assign in_i.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign q_vld_o    = (cnt_q != '0);
  assign pop        = q_pop_i && q_vld_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    item.lane  = in_i.lane;
    item.value = in_i.value;
    item.last  = in_i.lane_last;
    if (!active_i[in_i.lane]) begin
      item.op = OP_BAD_LANE;
    end else if (in_i.lane_empty) begin
      item.op = OP_FINISH;
    end else begin
      item.op = OP_LOAD;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ----- src/kwsm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwsm_back
// Holds the lane heads, applies queued items, flags rejected ones and emits
// the smallest head through a registered min tree and an output register.
// ----------------------------------------------------------------------------
module kwsm_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [kwsm_pkg::LANES-1:0] active_i,
  input  logic                    q_vld_i,
  input  kwsm_pkg::q_item_t       q_item_i,
  output logic                    q_pop_o,
  kwsm_out_if.source              out_o
);
  import kwsm_pkg::*;

  state_e                        state_q, state_d;
  logic [LANES-1:0]              present_q, present_d;
  logic [LANES-1:0]              finished_q, finished_d;
  logic [LANES-1:0]              tail_q, tail_d;
  logic signed [VALUE_WIDTH-1:0] head_q [LANES];
  logic                          head_we;

  cand_t                         pair_q [NPAIR];
  cand_t                         pair_d [NPAIR];
  cand_t                         tree [NPAIR];
  cand_t                         best;

  logic                          out_vld_q;
  logic signed [VALUE_WIDTH-1:0] out_val_q, out_val_d;
  logic [LANE_W-1:0]             out_lane_q, out_lane_d;
  logic                          out_done_q, out_done_d;
  logic                          out_err_q, out_err_d;
  logic                          out_load;
  logic                          out_free;

  logic                          err_sel;
  logic                          all_ready;
  logic                          all_done;
  logic [LANES-1:0]              fin_vec;

  assign out_free = !out_vld_q || out_o.ready;
  assign err_sel  = (q_item_i.op == OP_BAD_LANE) || present_q[q_item_i.lane]
                    || finished_q[q_item_i.lane];
  assign all_ready = &(present_q | finished_q | ~active_i);
  assign all_done  = &(finished_q | ~active_i);

  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      cand_t lo;
      cand_t hi;
      lo.vld   = present_q[2*p] && active_i[2*p];
      lo.lane  = LANE_W'(2*p);
      lo.value = head_q[2*p];
      hi       = '0;
      if (2*p + 1 < LANES) begin
        hi.vld   = present_q[2*p+1] && active_i[2*p+1];
        hi.lane  = LANE_W'(2*p + 1);
        hi.value = head_q[2*p+1];
      end
      pair_d[p] = min_of(lo, hi);
    end
  end

  always_comb begin
    for (int j = 0; j < NPAIR; j++) begin
      tree[j] = pair_q[j];
    end
    for (int s = 1; s < NPAIR; s = s * 2) begin
      for (int j = 0; j + s < NPAIR; j = j + 2 * s) begin
        tree[j] = min_of(tree[j], tree[j+s]);
      end
    end
    best = tree[0];
  end

  always_comb begin
    state_d    = state_q;
    present_d  = present_q;
    finished_d = finished_q;
    tail_d     = tail_q;
    head_we    = 1'b0;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    out_val_d  = out_val_q;
    out_lane_d = out_lane_q;
    out_done_d = 1'b0;
    out_err_d  = 1'b0;
    fin_vec    = finished_q;
    case (state_q)
      ST_IDLE: begin
        if (q_vld_i) begin
          if (err_sel) begin
            if (out_free) begin
              q_pop_o    = 1'b1;
              out_load   = 1'b1;
              out_val_d  = '0;
              out_lane_d = q_item_i.lane;
              out_err_d  = 1'b1;
            end
          end else begin
            q_pop_o = 1'b1;
            if (q_item_i.op == OP_FINISH) begin
              finished_d[q_item_i.lane] = 1'b1;
            end else begin
              head_we                  = 1'b1;
              present_d[q_item_i.lane] = 1'b1;
              tail_d[q_item_i.lane]    = q_item_i.last;
            end
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!all_ready) begin
          state_d = ST_IDLE;
        end else if (all_done) begin
          present_d  = '0;
          finished_d = '0;
          tail_d     = '0;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_val_d             = best.value;
          out_lane_d            = best.lane;
          present_d[best.lane]  = 1'b0;
          if (tail_q[best.lane]) begin
            tail_d[best.lane]     = 1'b0;
            finished_d[best.lane] = 1'b1;
            fin_vec[best.lane]    = 1'b1;
          end
          out_done_d = &(fin_vec | ~active_i);
          if (out_done_d) begin
            present_d  = '0;
            finished_d = '0;
            tail_d     = '0;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      present_q  <= '0;
      finished_q <= '0;
      tail_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      present_q  <= present_d;
      finished_q <= finished_d;
      tail_q     <= tail_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_q[q_item_i.lane] <= q_item_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int p = 0; p < NPAIR; p++) begin
      pair_q[p] <= pair_d[p];
    end
    if (out_load) begin
      out_val_q  <= out_val_d;
      out_lane_q <= out_lane_d;
      out_done_q <= out_done_d;
      out_err_q  <= out_err_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.merged_value   = out_val_q;
  assign out_o.source_lane    = out_lane_q;
  assign out_o.merge_done     = out_done_q;
  assign out_o.protocol_error = out_err_q;

`ifndef SYNTHESIS
  a_pick_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PICK |-> best.vld)
    else $error("min tree found no head in pick state");

  a_head_xor_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (present_q & finished_q) == '0)
    else $error("lane both holds a head and is finished");

  a_tail_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q & ~present_q) == '0)
    else $error("tail flag set on a lane without a head");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_done_d |=> present_q == '0 && finished_q == '0 && tail_q == '0)
    else $error("lane state not cleared after final element");

  a_error_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && err_sel && state_q == ST_IDLE
      |=> $stable(present_q) && $stable(finished_q) && $stable(tail_q))
    else $error("rejected item changed lane state");
`endif

endmodule

// ----- src/k_way_sorted_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merges up to LANES ascending signed streams into one ascending stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one element, or an empty-lane mark, for one lane per transfer.
//   out_o  : merged elements in ascending order, ties to the lowest lane;
//            merge_done flags the last element of a merge, protocol_error
//            flags an item for an inactive, occupied or finished lane.
//   cfg_we_i / cfg_wdata_i : number of active lanes (0 acts as 1, above
//            LANES acts as LANES); write only while the block is idle.
// Flow:
//   Items pass a two-entry queue into the merge engine, which takes one
//   item at a time: it applies the item and checks the readiness of all
//   lanes, then passes each emitted element through the pair compare
//   stage and the rest of the min tree into the output register. A
//   rejected item leaves the lanes unchanged and loads an error result.
// Reset and stall:
//   Reset clears all lanes, the queue and the output valid flag and sets the
//   active lane count to LANES. While out_o is stalled the engine holds its
//   pending element and the queue keeps taking items until full.
// ----------------------------------------------------------------------------
module k_way_sorted_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [kwsm_pkg::CFG_W-1:0] cfg_wdata_i,
  kwsm_in_if.sink                    in_i,
  kwsm_out_if.source                 out_o
);
  import kwsm_pkg::*;

  logic [LANES-1:0] active_q;
  logic             q_vld;
  q_item_t          q_item;
  logic             q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= lanes_mask(CFG_RESET);
    end else if (cfg_we_i) begin
      active_q <= lanes_mask(cfg_wdata_i);
    end
  end

  kwsm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .active_i (active_q),
    .in_i     (in_i),
    .q_vld_o  (q_vld),
    .q_item_o (q_item),
    .q_pop_i  (q_pop)
  );

  kwsm_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .active_i (active_q),
    .q_vld_i  (q_vld),
    .q_item_i (q_item),
    .q_pop_o  (q_pop),
    .out_o    (out_o)
  );

endmodule

// ----- dv/k_way_sorted_merge_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_tb
// Self-checking bench for the k-way sorted merge. A scoreboard class keeps
// its own copy of the lane heads and the lane count, and works out the
// merged elements and error results from each input transfer. Every output
// transfer is checked field by field against the oldest expected result.
// Stimulus is a short directed part, then mostly well-formed ascending
// streams per lane, salted with random noise, over several lane counts and
// idling patterns, including a long output stall.
// ----------------------------------------------------------------------------
package kwsm_tb_pkg;
  import kwsm_pkg::*;

  typedef struct packed {
    logic [LANE_W-1:0]             lane;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
    logic                          empty;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [LANE_W-1:0]             lane;
    logic                          done;
    logic                          err;
  } merge_res_t;

  class merge_scoreboard;
    logic [CFG_W-1:0]              lanes_reg;
    logic signed [VALUE_WIDTH-1:0] head_val [LANES];
    bit                            head_vld [LANES];
    bit                            lane_fin [LANES];
    bit                            tail_flag [LANES];
    merge_res_t                    merged_q [$];
    int                            n_in;
    int                            n_elem;
    int                            n_err;
    int                            n_merges;
    int                            n_fail;

    function new();
      lanes_reg = CFG_RESET;
      clear_lanes();
    endfunction

    function void clear_lanes();
      for (int i = 0; i < LANES; i++) begin
        head_val[i]  = '0;
        head_vld[i]  = 1'b0;
        lane_fin[i]  = 1'b0;
        tail_flag[i] = 1'b0;
      end
    endfunction

    function int active_count();
      int n;
      n = int'(lanes_reg);
      if (n < 1) n = 1;
      if (n > LANES) n = LANES;
      return n;
    endfunction

    function void write_lanes(logic [CFG_W-1:0] v);
      lanes_reg = v;
    endfunction

    function bit lane_open(int l);
      return (l < active_count()) && !head_vld[l] && !lane_fin[l];
    endfunction

    function bit merge_clear();
      for (int i = 0; i < LANES; i++) begin
        if (head_vld[i] || lane_fin[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return merged_q.size();
    endfunction

    function void note_input(in_item_t it);
      int         n;
      int         l;
      int         best;
      bit         all_in;
      bit         all_fin;
      merge_res_t r;
      n = active_count();
      l = int'(it.lane);
      n_in++;
      if (l >= n || head_vld[l] || lane_fin[l]) begin
        r = '{value: '0, lane: it.lane, done: 1'b0, err: 1'b1};
        merged_q.push_back(r);
        return;
      end
      if (it.empty) begin
        lane_fin[l] = 1'b1;
      end else begin
        head_val[l]  = it.value;
        head_vld[l]  = 1'b1;
        tail_flag[l] = it.last;
      end
      forever begin
        all_in  = 1'b1;
        all_fin = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (!head_vld[i] && !lane_fin[i]) all_in = 1'b0;
          if (!lane_fin[i]) all_fin = 1'b0;
        end
        if (!all_in) break;
        if (all_fin) begin
          // every lane finished with no head left: nothing to emit
          clear_lanes();
          break;
        end
        best = -1;
        for (int i = 0; i < n; i++) begin
          if (head_vld[i] && (best < 0 || head_val[i] < head_val[best])) best = i;
        end
        if (best < 0) break;
        head_vld[best] = 1'b0;
        if (tail_flag[best]) begin
          tail_flag[best] = 1'b0;
          lane_fin[best]  = 1'b1;
        end
        all_fin = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (!lane_fin[i]) all_fin = 1'b0;
        end
        r = '{value: head_val[best], lane: LANE_W'(best), done: all_fin, err: 1'b0};
        merged_q.push_back(r);
        if (all_fin) begin
          clear_lanes();
          break;
        end
      end
    endfunction

    function void check_result(merge_res_t got);
      merge_res_t exp;
      if (merged_q.size() == 0) begin
        $error("unexpected result: merged_value %0d source_lane %0d merge_done %0b error %0b",
               got.value, got.lane, got.done, got.err);
        n_fail++;
        return;
      end
      exp = merged_q.pop_front();
      if (got.value !== exp.value) begin
        $error("merged_value: expected %0d, got %0d", exp.value, got.value);
        n_fail++;
      end
      if (got.lane !== exp.lane) begin
        $error("source_lane: expected %0d, got %0d", exp.lane, got.lane);
        n_fail++;
      end
      if (got.done !== exp.done) begin
        $error("merge_done: expected %0b, got %0b", exp.done, got.done);
        n_fail++;
      end
      if (got.err !== exp.err) begin
        $error("protocol_error: expected %0b, got %0b", exp.err, got.err);
        n_fail++;
      end
      if (exp.err) n_err++;
      else n_elem++;
      if (exp.done) n_merges++;
    endfunction
  endclass
endpackage

module k_way_sorted_merge_tb;
  import kwsm_pkg::*;
  import kwsm_tb_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int N_PHASES       = 9;
  localparam int PHASE_ITEMS    = 40;
  localparam int PRESSURE_PHASE = 4;
  localparam int DRAIN_PHASE    = 1;
  localparam int HOLD_CYCLES    = 300;
  localparam int NOISE_PCT      = 12;
  localparam logic signed [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  kwsm_in_if  in_ch ();
  kwsm_out_if out_ch ();

  k_way_sorted_merge u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  merge_scoreboard sb = new();

  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_left;
  longint lane_floor [LANES];
  bit     floor_set [LANES];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    merge_res_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got = '{value: out_ch.merged_value, lane: out_ch.source_lane,
                done: out_ch.merge_done, err: out_ch.protocol_error};
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic in_item_t mk(int l, logic signed [VALUE_WIDTH-1:0] v, bit last,
                                  bit empty);
    in_item_t it;
    it.lane  = LANE_W'(l);
    it.value = v;
    it.last  = last;
    it.empty = empty;
    return it;
  endfunction

  function automatic bit pick_open(output int l);
    int open_q [$];
    for (int i = 0; i < LANES; i++) begin
      if (sb.lane_open(i)) open_q.push_back(i);
    end
    l = 0;
    if (open_q.size() == 0) return 1'b0;
    l = open_q[$urandom_range(0, open_q.size() - 1)];
    return 1'b1;
  endfunction

  function automatic in_item_t make_item();
    in_item_t it;
    int       l;
    longint   v;
    bit       at_top;
    if (sb.merge_clear()) begin
      for (int i = 0; i < LANES; i++) floor_set[i] = 1'b0;
    end
    it.value = $urandom;
    it.last  = $urandom_range(0, 1);
    it.empty = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 99) < NOISE_PCT || !pick_open(l)) begin
      it.lane = LANE_W'($urandom_range(0, LANES - 1));
      return it;
    end
    it.lane = LANE_W'(l);
    if ($urandom_range(0, 9) == 0) begin
      it.empty = 1'b1;
      return it;
    end
    it.empty = 1'b0;
    at_top   = 1'b0;
    if (!floor_set[l]) begin
      case ($urandom_range(0, 3))
        0: v = longint'($signed(VALUE_WIDTH'($urandom)));
        1: v = longint'(V_MIN) + longint'($urandom_range(0, 2000));
        2: v = longint'(V_MAX) - longint'($urandom_range(0, 2000));
        default: v = longint'($urandom_range(0, 2000)) - 1000;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: v = lane_floor[l];
        1: v = lane_floor[l] + longint'($urandom_range(1, 50));
        default: v = lane_floor[l] + longint'($urandom_range(1, 1 << 20));
      endcase
    end
    if (v >= longint'(V_MAX)) begin
      v      = longint'(V_MAX);
      at_top = 1'b1;
    end
    lane_floor[l] = v;
    floor_set[l]  = 1'b1;
    it.value = VALUE_WIDTH'(v);
    it.last  = at_top || ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  task automatic drive_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.lane       <= it.lane;
    in_ch.value      <= it.value;
    in_ch.lane_last  <= it.last;
    in_ch.lane_empty <= it.empty;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_lanes(input logic [CFG_W-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_lanes(v);
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct  = 57;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 57;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 22;
        recv_stall_pct = 22;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Finish every open lane empty until the merge has cleared.
  task automatic close_merge();
    int l;
    while (!sb.merge_clear() && pick_open(l)) begin
      drive_item(mk(l, $urandom, $urandom_range(0, 1), 1'b1));
    end
  endtask

  initial begin
    int unsigned phase_cfg [N_PHASES];
    phase_cfg        = '{8, 3, 1, 15, 7, 0, 5, 2, 9};
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_ch.valid      = 1'b0;
    in_ch.lane       = '0;
    in_ch.value      = '0;
    in_ch.lane_last  = 1'b0;
    in_ch.lane_empty = 1'b0;
    out_ch.ready     = 1'b0;
    hold_left        = 0;
    set_idling(IDLE_NONE);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ties at the minimum, occupied and finished lanes, a seven-element release
    drive_item(mk(0, V_MIN, 1'b0, 1'b0));
    drive_item(mk(1, V_MAX, 1'b1, 1'b0));
    drive_item(mk(2, 0, 1'b1, 1'b0));
    drive_item(mk(3, V_MIN, 1'b1, 1'b0));
    drive_item(mk(4, 0, 1'b0, 1'b1));
    drive_item(mk(5, -1, 1'b1, 1'b0));
    drive_item(mk(6, 5, 1'b1, 1'b0));
    drive_item(mk(0, 7, 1'b1, 1'b0));
    drive_item(mk(7, 5, 1'b1, 1'b0));
    drive_item(mk(4, 1, 1'b0, 1'b0));
    drive_item(mk(0, V_MIN, 1'b1, 1'b0));
    // release all eight lanes with one transfer
    for (int l = LANES - 1; l >= 0; l--) begin
      drive_item(mk(l, 3 * l - 10, 1'b1, 1'b0));
    end
    // zero lanes acts as one: empty merge, inactive lane, single element
    write_lanes(CFG_W'(0));
    drive_item(mk(0, 0, 1'b0, 1'b1));
    drive_item(mk(1, 42, 1'b1, 1'b0));
    drive_item(mk(0, V_MAX, 1'b1, 1'b0));
    // lane count changed with heads held
    write_lanes(CFG_W'(15));
    drive_item(mk(0, 10, 1'b1, 1'b0));
    drive_item(mk(3, 5, 1'b0, 1'b0));
    write_lanes(CFG_W'(2));
    drive_item(mk(1, 7, 1'b1, 1'b0));

    for (int p = 0; p < N_PHASES; p++) begin
      write_lanes(CFG_W'(phase_cfg[p]));
      set_idling(idle_mode_e'(p % 4));
      if (p == PRESSURE_PHASE) hold_left = HOLD_CYCLES;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == DRAIN_PHASE && k == PHASE_ITEMS / 2) settle();
        drive_item(make_item());
      end
      close_merge();
    end

    set_idling(IDLE_NONE);
    settle();
    $display("Covered %0d input transfers: %0d merged elements, %0d error results, %0d merges",
             sb.n_in, sb.n_elem, sb.n_err, sb.n_merges);
    $display("Lane counts 0 to 15 applied, idling on either side, one long output stall");
    if (sb.n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- k_way_sorted_merge.f -----
src/kwsm_pkg.sv
src/kwsm_if.sv
src/kwsm_front.sv
src/kwsm_back.sv
src/k_way_sorted_merge.sv
dv/k_way_sorted_merge_tb.sv
